// ----- rtl/range_add_count_at_least_macros.svh -----
// Assertion macros shared by the checker of the range add / count block.
// Holds macros only; no other dependencies.
`ifndef RANGE_ADD_COUNT_AT_LEAST_MACROS_SVH
`define RANGE_ADD_COUNT_AT_LEAST_MACROS_SVH
`define RACAL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
`define RACAL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// ----- rtl/racal_pkg.sv -----
// Shared types and codes of the range add / count block.
// No dependencies.
`timescale 1ns / 1ps
package racal_pkg;
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_COUNT = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;
	localparam int LIM_W   = 11;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef struct packed {
		logic       active;
		logic       do_add;
		logic       do_count;
		value_t     amount;
	} sweep_ctl_t;
endpackage

// ----- rtl/range_add_count_at_least.sv -----
// Top level of the range add / count block: a row of element cells and a count sequencer.
// Depends on racal_pkg and racal_cell.
// Loads and adds leave busy low, since every cell updates its own element in parallel.
// A count word latches each cell's compare bit at start and then shifts the bits down the
// row of cells, one per cycle, into a counter. Busy stays high while the bits shift, and
// done with the count rises at the same edge at which busy falls. Done is a one-cycle
// strobe; the receiver cannot stall. No start is taken while busy is high.
`timescale 1ns / 1ps
module range_add_count_at_least #(
	parameter int DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [9:0]  lo,
	input  logic [9:0]  hi,
	input  logic signed [31:0] amount,
	input  logic        cfg_we,
	input  logic [10:0] cfg_data,
	output logic        done,
	output logic [10:0] count
);
	import racal_pkg::*;
	localparam int IW = $clog2(DEPTH + 1);
	logic [LIM_W-1:0] n_q;
	logic [IW-1:0] n_eff;
	sweep_ctl_t ctl;
	logic accept;
	logic busy_q;
	logic [IW-1:0] left_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] cnt_nx;
	logic [DEPTH:0] chain;
	assign n_eff = (32'(n_q) > 32'(DEPTH)) ? IW'(DEPTH) : IW'(n_q);
	assign accept = start && !busy_q;
	assign busy = busy_q;
	assign ctl.active = accept;
	assign ctl.do_add = (func == FUNC_ADD);
	assign ctl.do_count = (func == FUNC_COUNT);
	assign ctl.amount = amount;
	assign chain[DEPTH] = 1'b0;
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic inr;
		logic ld;
		assign inr = (32'(g) >= 32'(lo)) && (32'(g) <= 32'(hi)) && (32'(g) < 32'(n_eff));
		assign ld = accept && (func == FUNC_LOAD) && (32'(g) == 32'(lo))
			&& (32'(g) < 32'(n_eff));
		racal_cell u_cell (
			.clk(clk), .ctl(ctl), .load_en(ld), .in_range(inr),
			.load_value(amount), .chain_in(chain[g+1]), .chain_out(chain[g])
		);
	end
	assign cnt_nx = cnt_q + COUNT_W'(chain[0]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 11'd1024;
			busy_q <= 1'b0;
			left_q <= '0;
			cnt_q <= '0;
			done <= 1'b0;
			count <= '0;
		end else begin
			if (cfg_we) n_q <= cfg_data;
			if (accept && (func == FUNC_COUNT)) begin
				busy_q <= 1'b1;
				left_q <= IW'(DEPTH);
				cnt_q <= '0;
				done <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_nx;
				left_q <= left_q - IW'(1);
				if (left_q == IW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
					count <= cnt_nx;
				end else begin
					done <= 1'b0;
				end
			end else begin
				done <= 1'b0;
			end
		end
	end
endmodule

// ----- rtl/racal_cell.sv -----
// One storage cell of the array: holds one element, adds with saturation and compares.
// Its compare bit is handed to the neighbor cell every cycle. Depends on racal_pkg.
`timescale 1ns / 1ps
module racal_cell (
	input  logic                clk,
	input  racal_pkg::sweep_ctl_t ctl,
	input  logic                load_en,
	input  logic                in_range,
	input  racal_pkg::value_t   load_value,
	input  logic                chain_in,
	output logic                chain_out
);
	import racal_pkg::*;
	value_t value_q;
	logic signed [VALUE_W:0] sum;
	value_t sat;
	logic hit;
	logic chain_q;
	assign sum = {value_q[VALUE_W-1], value_q} + {ctl.amount[VALUE_W-1], ctl.amount};
	always_comb begin
		if (sum[VALUE_W] != sum[VALUE_W-1]) begin
			sat = sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
		end else begin
			sat = sum[VALUE_W-1:0];
		end
	end
	assign hit = ctl.do_count && in_range && (value_q >= ctl.amount);
	assign chain_out = chain_q;
	always_ff @(posedge clk) begin
		if (load_en) begin
			value_q <= load_value;
		end else if (ctl.active && ctl.do_add && in_range) begin
			value_q <= sat;
		end
	end
	always_ff @(posedge clk) begin
		chain_q <= (ctl.active && ctl.do_count) ? hit : chain_in;
	end
endmodule

// ----- rtl/racal_checker.sv -----
// Port checker for the range add / count block, bound to the top level.
// Depends on racal_pkg and range_add_count_at_least_macros.svh.
`timescale 1ns / 1ps
`include "range_add_count_at_least_macros.svh"
module racal_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [1:0] func,
	input logic done,
	input logic [10:0] count
);
	import racal_pkg::*;
	`RACAL_ASSERT_IMP(a_cnt_bound, done, count <= 11'd1024)
	`RACAL_ASSERT_NEXT(a_busy_after_count, start && !busy && func == FUNC_COUNT, busy)
	`RACAL_ASSERT_NEXT(a_idle_after_other, start && !busy && func != FUNC_COUNT, !busy)
	`RACAL_ASSERT_IMP(a_done_idle, done, !busy)
	`RACAL_ASSERT_NEXT(a_done_pulse, done, !done)
endmodule
bind range_add_count_at_least racal_checker u_racal_checker (.*);
